/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the rectangle region block.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RRIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RRIE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define RRIE_ASSERT(lbl, prop, msg)
`define RRIE_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/rrie_pkg.sv */
// Shared types, constants and helpers of the rectangle region block.
// No dependencies; used by the controller, the datapath and the top level.
package rrie_pkg;

  localparam int MAX_RECTS   = 32;
  localparam int MAX_PENDING = 32;
  localparam int COORD_BITS  = 12;
  localparam int RIDX_W      = $clog2(MAX_RECTS);
  localparam int PIDX_W      = $clog2(MAX_PENDING);
  localparam int RCNT_W      = $clog2(MAX_RECTS + 1);
  localparam int PCNT_W      = $clog2(MAX_PENDING + 1);
  localparam int CNT_W       = (RCNT_W > PCNT_W) ? RCNT_W : PCNT_W;
  localparam int ECNT_W      = 6;
  localparam int KIND_W      = 2;
  localparam int OP_W        = 5;

  localparam logic [KIND_W-1:0] KIND_INC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIST = 2'd2;

  localparam logic [3:0] EDGE_L    = 4'h1;
  localparam logic [3:0] EDGE_T    = 4'h2;
  localparam logic [3:0] EDGE_R    = 4'h4;
  localparam logic [3:0] EDGE_B    = 4'h8;
  localparam logic [3:0] SAME_NONE = 4'h0;
  localparam logic [3:0] SAME_ALL  = 4'hF;

  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_START    = 5'd1;
  localparam logic [OP_W-1:0] OP_PUSH_IN  = 5'd2;
  localparam logic [OP_W-1:0] OP_RD_E     = 5'd3;
  localparam logic [OP_W-1:0] OP_LD_E     = 5'd4;
  localparam logic [OP_W-1:0] OP_RD_P     = 5'd5;
  localparam logic [OP_W-1:0] OP_LD_P     = 5'd6;
  localparam logic [OP_W-1:0] OP_SKIP     = 5'd7;
  localparam logic [OP_W-1:0] OP_GONE     = 5'd8;
  localparam logic [OP_W-1:0] OP_FIX      = 5'd9;
  localparam logic [OP_W-1:0] OP_WR_P     = 5'd10;
  localparam logic [OP_W-1:0] OP_ERS_INIT = 5'd11;
  localparam logic [OP_W-1:0] OP_RD_SH    = 5'd12;
  localparam logic [OP_W-1:0] OP_WR_SH    = 5'd13;
  localparam logic [OP_W-1:0] OP_ERS_END  = 5'd14;
  localparam logic [OP_W-1:0] OP_KEEP     = 5'd15;
  localparam logic [OP_W-1:0] OP_SIDE     = 5'd16;
  localparam logic [OP_W-1:0] OP_FIN      = 5'd17;
  localparam logic [OP_W-1:0] OP_RD_A     = 5'd18;
  localparam logic [OP_W-1:0] OP_WR_A     = 5'd19;
  localparam logic [OP_W-1:0] OP_RD_L     = 5'd20;
  localparam logic [OP_W-1:0] OP_EMIT_L   = 5'd21;
  localparam logic [OP_W-1:0] OP_EMIT_S   = 5'd22;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t b;
    coord_t r;
    coord_t t;
    coord_t l;
  } box_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic x_empty;
    logic r_more;
    logic p_more;
    logic m_empty;
    logic same_all;
    logic same_none;
    logic sh_more;
    logic ap_more;
    logic xm_empty;
    logic sd_last;
    logic l_more;
    logic tbl_empty;
    logic out_busy;
  } stat_t;

  function automatic logic box_empty(box_t a);
    return (a.r <= a.l) || (a.b <= a.t);
  endfunction

  function automatic box_t box_isect(box_t a, box_t c);
    box_t m;
    m.l = (a.l > c.l) ? a.l : c.l;
    m.t = (a.t > c.t) ? a.t : c.t;
    m.r = (a.r < c.r) ? a.r : c.r;
    m.b = (a.b < c.b) ? a.b : c.b;
    return m;
  endfunction

endpackage

/* hw/rtl/rrie_ctrl.sv */
// Sequencing state machine of the rectangle region block.
// Depends on rrie_pkg; drives datapath commands from datapath status.
module rrie_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [rrie_pkg::KIND_W-1:0] in_kind_i,
  output logic                        in_ready_o,
  output rrie_pkg::cmd_t              cmd_o,
  input  rrie_pkg::stat_t             stat_i
);
  import rrie_pkg::*;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE = 5'd0;
  localparam logic [ST_W-1:0] S_DISP = 5'd1;
  localparam logic [ST_W-1:0] S_RCHK = 5'd2;
  localparam logic [ST_W-1:0] S_LDE  = 5'd3;
  localparam logic [ST_W-1:0] S_PCHK = 5'd4;
  localparam logic [ST_W-1:0] S_LDP  = 5'd5;
  localparam logic [ST_W-1:0] S_CLS  = 5'd6;
  localparam logic [ST_W-1:0] S_WRP  = 5'd7;
  localparam logic [ST_W-1:0] S_ERS  = 5'd8;
  localparam logic [ST_W-1:0] S_ERW  = 5'd9;
  localparam logic [ST_W-1:0] S_XCHK = 5'd10;
  localparam logic [ST_W-1:0] S_XSD  = 5'd11;
  localparam logic [ST_W-1:0] S_APC  = 5'd12;
  localparam logic [ST_W-1:0] S_APW  = 5'd13;
  localparam logic [ST_W-1:0] S_STAT = 5'd14;
  localparam logic [ST_W-1:0] S_LCHK = 5'd15;
  localparam logic [ST_W-1:0] S_LEM  = 5'd16;

  logic [ST_W-1:0]   state_q, state_d;
  logic [KIND_W-1:0] kind_q, kind_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_START;
          kind_d   = in_kind_i;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        case (kind_q)
          KIND_LIST: state_d = S_LCHK;
          KIND_INC: begin
            if (stat_i.x_empty) begin
              state_d = S_STAT;
            end else begin
              cmd_o.op = OP_PUSH_IN;
              state_d  = S_RCHK;
            end
          end
          KIND_EXC: state_d = S_RCHK;
          default:  state_d = S_STAT;
        endcase
      end
      S_RCHK: begin
        if (stat_i.r_more) begin
          cmd_o.op = OP_RD_E;
          state_d  = S_LDE;
        end else begin
          cmd_o.op = OP_FIN;
          state_d  = S_APC;
        end
      end
      S_LDE: begin
        cmd_o.op = OP_LD_E;
        state_d  = (kind_q == KIND_INC) ? S_PCHK : S_XCHK;
      end
      S_PCHK: begin
        if (stat_i.p_more) begin
          cmd_o.op = OP_RD_P;
          state_d  = S_LDP;
        end else begin
          cmd_o.op = OP_KEEP;
          state_d  = S_RCHK;
        end
      end
      S_LDP: begin
        cmd_o.op = OP_LD_P;
        state_d  = S_CLS;
      end
      S_CLS: begin
        if (stat_i.m_empty) begin
          cmd_o.op = OP_SKIP;
          state_d  = S_PCHK;
        end else if (stat_i.same_all) begin
          cmd_o.op = OP_ERS_INIT;
          state_d  = S_ERS;
        end else if (stat_i.same_none) begin
          cmd_o.op = OP_GONE;
          state_d  = S_PCHK;
        end else begin
          cmd_o.op = OP_FIX;
          state_d  = S_WRP;
        end
      end
      S_WRP: begin
        cmd_o.op = OP_WR_P;
        state_d  = S_PCHK;
      end
      S_ERS: begin
        if (stat_i.sh_more) begin
          cmd_o.op = OP_RD_SH;
          state_d  = S_ERW;
        end else begin
          cmd_o.op = OP_ERS_END;
          state_d  = S_PCHK;
        end
      end
      S_ERW: begin
        cmd_o.op = OP_WR_SH;
        state_d  = S_ERS;
      end
      S_XCHK: begin
        if (stat_i.xm_empty) begin
          cmd_o.op = OP_KEEP;
          state_d  = S_RCHK;
        end else begin
          state_d  = S_XSD;
        end
      end
      S_XSD: begin
        cmd_o.op = OP_SIDE;
        if (stat_i.sd_last) state_d = S_RCHK;
      end
      S_APC: begin
        if (stat_i.ap_more) begin
          cmd_o.op = OP_RD_A;
          state_d  = S_APW;
        end else begin
          state_d  = S_STAT;
        end
      end
      S_APW: begin
        cmd_o.op = OP_WR_A;
        state_d  = S_APC;
      end
      S_STAT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_EMIT_S;
          state_d  = S_IDLE;
        end
      end
      S_LCHK: begin
        if (stat_i.tbl_empty) begin
          state_d = S_STAT;
        end else if (stat_i.l_more) begin
          cmd_o.op = OP_RD_L;
          state_d  = S_LEM;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LEM: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_EMIT_L;
          state_d  = S_LCHK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= KIND_INC;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

/* hw/rtl/rrie_datapath.sv */
// Datapath of the rectangle region block: rectangle table, scratch list,
// counters, edge classification and output register. Depends on rrie_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rrie_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrie_pkg::cmd_t              cmd_i,
  output rrie_pkg::stat_t             stat_o,
  input  rrie_pkg::box_t              in_box_i,
  output rrie_pkg::box_t              out_box_o,
  output logic                        out_has_o,
  output logic                        out_last_o,
  output logic                        out_ovf_o,
  output logic [rrie_pkg::ECNT_W-1:0] out_cnt_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i
);
  import rrie_pkg::*;

  box_t tbl_mem [MAX_RECTS];
  box_t pnd_mem [MAX_PENDING];
  box_t tbl_rd_q, pnd_rd_q;

  box_t x_q, e_q, p_q;
  logic [CNT_W-1:0] r_q, w_q, rcnt_q, pcnt_q, j_q, js_q, k_q;
  logic [1:0] sd_q;
  logic gone_q, ovf_q, out_valid_q;

  box_t out_box_q;
  logic out_has_q, out_last_q, out_ovf_q;
  logic [ECNT_W-1:0] out_cnt_q;

  box_t m_inc, m_exc;
  logic [3:0] same;
  logic [CNT_W-1:0] kp1;
  logic pnd_room, tbl_room, keep_ok;

  box_t fix_e, fix_p, fix_piece;
  logic fix_push;
  box_t side_piece;
  logic side_cond;

  logic tbl_we, tbl_re, pnd_we, pnd_re;
  logic [RIDX_W-1:0] tbl_wa, tbl_ra;
  logic [PIDX_W-1:0] pnd_wa, pnd_ra;
  box_t tbl_wd, pnd_wd;

  function automatic box_t mkb(coord_t l, coord_t t, coord_t r, coord_t b);
    box_t v;
    v.l = l; v.t = t; v.r = r; v.b = b;
    return v;
  endfunction

  assign m_inc    = box_isect(e_q, p_q);
  assign m_exc    = box_isect(e_q, x_q);
  assign same     = ((p_q.l == m_inc.l) ? EDGE_L : 4'h0) | ((p_q.t == m_inc.t) ? EDGE_T : 4'h0) |
                    ((p_q.r == m_inc.r) ? EDGE_R : 4'h0) | ((p_q.b == m_inc.b) ? EDGE_B : 4'h0);
  assign kp1      = k_q + 1'b1;
  assign pnd_room = pcnt_q < CNT_W'(MAX_PENDING);
  assign tbl_room = rcnt_q < CNT_W'(MAX_RECTS);
  assign keep_ok  = !gone_q && !box_empty(e_q);

  // include: edge-match class of a piece against the current entry
  always_comb begin
    fix_e     = e_q;
    fix_p     = p_q;
    fix_piece = p_q;
    fix_push  = 1'b0;
    case (same)
      EDGE_T | EDGE_R | EDGE_B: fix_p = mkb(p_q.l, m_inc.t, m_inc.l, m_inc.b);
      EDGE_L | EDGE_R | EDGE_B: fix_p = mkb(m_inc.l, p_q.t, m_inc.r, m_inc.t);
      EDGE_L | EDGE_T | EDGE_B: fix_p = mkb(m_inc.r, m_inc.t, p_q.r, m_inc.b);
      EDGE_L | EDGE_T | EDGE_R: fix_p = mkb(m_inc.l, m_inc.b, m_inc.r, p_q.b);
      EDGE_L: fix_e = mkb(e_q.l, m_inc.t, m_inc.l, m_inc.b);
      EDGE_T: fix_e = mkb(m_inc.l, e_q.t, m_inc.r, m_inc.t);
      EDGE_R: fix_e = mkb(m_inc.r, m_inc.t, e_q.r, m_inc.b);
      EDGE_B: fix_e = mkb(m_inc.l, m_inc.b, m_inc.r, e_q.b);
      EDGE_L | EDGE_T: begin
        fix_push  = 1'b1;
        fix_piece = mkb(p_q.l, m_inc.b, p_q.r, p_q.b);
        fix_p     = mkb(m_inc.r, m_inc.t, p_q.r, m_inc.b);
      end
      EDGE_L | EDGE_B: begin
        fix_push  = 1'b1;
        fix_piece = mkb(p_q.l, p_q.t, p_q.r, m_inc.t);
        fix_p     = mkb(m_inc.r, m_inc.t, p_q.r, m_inc.b);
      end
      EDGE_R | EDGE_T: begin
        fix_push  = 1'b1;
        fix_piece = mkb(p_q.l, m_inc.b, p_q.r, p_q.b);
        fix_p     = mkb(p_q.l, m_inc.t, m_inc.l, m_inc.b);
      end
      EDGE_R | EDGE_B: begin
        fix_push  = 1'b1;
        fix_piece = mkb(p_q.l, p_q.t, p_q.r, m_inc.t);
        fix_p     = mkb(p_q.l, m_inc.t, m_inc.l, m_inc.b);
      end
      EDGE_L | EDGE_R: begin
        fix_push  = 1'b1;
        fix_piece = mkb(p_q.l, p_q.t, p_q.r, m_inc.t);
        fix_p     = mkb(m_inc.l, m_inc.b, m_inc.r, p_q.b);
      end
      default: begin
        // top and bottom match
        fix_push  = 1'b1;
        fix_piece = mkb(m_inc.r, m_inc.t, p_q.r, m_inc.b);
        fix_p     = mkb(p_q.l, m_inc.t, m_inc.l, m_inc.b);
      end
    endcase
  end

  // exclude: side pieces, top, left, right, bottom
  always_comb begin
    case (sd_q)
      2'd0: begin
        side_cond  = e_q.t != m_exc.t;
        side_piece = mkb(e_q.l, e_q.t, e_q.r, m_exc.t);
      end
      2'd1: begin
        side_cond  = e_q.l != m_exc.l;
        side_piece = mkb(e_q.l, m_exc.t, m_exc.l, m_exc.b);
      end
      2'd2: begin
        side_cond  = e_q.r != m_exc.r;
        side_piece = mkb(m_exc.r, m_exc.t, e_q.r, m_exc.b);
      end
      default: begin
        side_cond  = e_q.b != m_exc.b;
        side_piece = mkb(e_q.l, m_exc.b, e_q.r, e_q.b);
      end
    endcase
  end

  always_comb begin
    tbl_we = 1'b0; tbl_wa = w_q[RIDX_W-1:0]; tbl_wd = e_q;
    tbl_re = 1'b0; tbl_ra = r_q[RIDX_W-1:0];
    pnd_we = 1'b0; pnd_wa = pcnt_q[PIDX_W-1:0]; pnd_wd = x_q;
    pnd_re = 1'b0; pnd_ra = j_q[PIDX_W-1:0];
    case (cmd_i.op)
      OP_RD_E: tbl_re = 1'b1;
      OP_RD_L: begin
        tbl_re = 1'b1;
        tbl_ra = k_q[RIDX_W-1:0];
      end
      OP_KEEP: tbl_we = keep_ok;
      OP_WR_A: begin
        tbl_we = tbl_room;
        tbl_wa = rcnt_q[RIDX_W-1:0];
        tbl_wd = pnd_rd_q;
      end
      OP_PUSH_IN: begin
        pnd_we = 1'b1;
        pnd_wa = '0;
      end
      OP_RD_P: pnd_re = 1'b1;
      OP_FIX: begin
        pnd_we = fix_push && pnd_room;
        pnd_wd = fix_piece;
      end
      OP_WR_P: begin
        pnd_we = 1'b1;
        pnd_wa = j_q[PIDX_W-1:0];
        pnd_wd = p_q;
      end
      OP_RD_SH: begin
        pnd_re = 1'b1;
        pnd_ra = kp1[PIDX_W-1:0];
      end
      OP_WR_SH: begin
        pnd_we = 1'b1;
        pnd_wa = k_q[PIDX_W-1:0];
        pnd_wd = pnd_rd_q;
      end
      OP_SIDE: begin
        pnd_we = side_cond && pnd_room;
        pnd_wd = side_piece;
      end
      OP_RD_A: begin
        pnd_re = 1'b1;
        pnd_ra = k_q[PIDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    if (tbl_re) tbl_rd_q <= tbl_mem[tbl_ra];
    if (pnd_we) pnd_mem[pnd_wa] <= pnd_wd;
    if (pnd_re) pnd_rd_q <= pnd_mem[pnd_ra];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: x_q <= in_box_i;
      OP_LD_E:  e_q <= tbl_rd_q;
      OP_LD_P:  p_q <= pnd_rd_q;
      OP_FIX: begin
        e_q <= fix_e;
        p_q <= fix_p;
      end
      OP_EMIT_L: begin
        out_box_q  <= tbl_rd_q;
        out_has_q  <= 1'b1;
        out_last_q <= (kp1 == rcnt_q);
        out_cnt_q  <= ECNT_W'(rcnt_q);
        out_ovf_q  <= ovf_q;
      end
      OP_EMIT_S: begin
        out_box_q  <= '0;
        out_has_q  <= 1'b0;
        out_last_q <= 1'b1;
        out_cnt_q  <= ECNT_W'(rcnt_q);
        out_ovf_q  <= ovf_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0; w_q <= '0; rcnt_q <= '0; pcnt_q <= '0;
      j_q <= '0; js_q <= '0; k_q <= '0; sd_q <= '0;
      gone_q <= 1'b0; ovf_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_START: begin
          pcnt_q <= '0; r_q <= '0; w_q <= '0; k_q <= '0;
        end
        OP_PUSH_IN: pcnt_q <= CNT_W'(1);
        OP_LD_E: begin
          gone_q <= 1'b0; j_q <= '0; js_q <= pcnt_q; sd_q <= '0;
        end
        OP_SKIP, OP_WR_P: begin
          j_q  <= j_q + 1'b1;
          js_q <= js_q - 1'b1;
        end
        OP_GONE: gone_q <= 1'b1;
        OP_FIX: begin
          if (fix_push) begin
            if (pnd_room) pcnt_q <= pcnt_q + 1'b1;
            else          ovf_q  <= 1'b1;
          end
        end
        OP_ERS_INIT: k_q <= j_q;
        OP_WR_SH:    k_q <= kp1;
        OP_ERS_END: begin
          pcnt_q <= pcnt_q - 1'b1;
          js_q   <= js_q - 1'b1;
        end
        OP_KEEP: begin
          if (keep_ok) w_q <= w_q + 1'b1;
          r_q <= r_q + 1'b1;
        end
        OP_SIDE: begin
          if (side_cond) begin
            if (pnd_room) pcnt_q <= pcnt_q + 1'b1;
            else          ovf_q  <= 1'b1;
          end
          sd_q <= sd_q + 1'b1;
          if (sd_q == 2'd3) r_q <= r_q + 1'b1;
        end
        OP_FIN: begin
          rcnt_q <= w_q;
          k_q    <= '0;
        end
        OP_WR_A: begin
          if (tbl_room) rcnt_q <= rcnt_q + 1'b1;
          else          ovf_q  <= 1'b1;
          k_q <= kp1;
        end
        OP_EMIT_L: begin
          k_q         <= kp1;
          out_valid_q <= 1'b1;
        end
        OP_EMIT_S: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign stat_o.x_empty   = box_empty(x_q);
  assign stat_o.r_more    = r_q < rcnt_q;
  assign stat_o.p_more    = (js_q != '0) && (j_q < pcnt_q) && !gone_q;
  assign stat_o.m_empty   = box_empty(m_inc);
  assign stat_o.same_all  = same == SAME_ALL;
  assign stat_o.same_none = same == SAME_NONE;
  assign stat_o.sh_more   = kp1 < pcnt_q;
  assign stat_o.ap_more   = k_q < pcnt_q;
  assign stat_o.xm_empty  = box_empty(m_exc);
  assign stat_o.sd_last   = sd_q == 2'd3;
  assign stat_o.l_more    = k_q < rcnt_q;
  assign stat_o.tbl_empty = rcnt_q == '0;
  assign stat_o.out_busy  = out_valid_q;

  assign out_box_o   = out_box_q;
  assign out_has_o   = out_has_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;
  assign out_cnt_o   = out_cnt_q;
  assign out_valid_o = out_valid_q;

  `RRIE_ASSERT(a_pcnt_bound, pcnt_q <= CNT_W'(MAX_PENDING), "scratch count beyond depth")
  `RRIE_ASSERT(a_rcnt_bound, rcnt_q <= CNT_W'(MAX_RECTS), "table count beyond depth")
  `RRIE_ASSERT(a_wr_behind_rd, w_q <= r_q, "compaction write pointer passed read pointer")
  `RRIE_ASSERT_IMP(a_emit_free, cmd_i.op == OP_EMIT_L || cmd_i.op == OP_EMIT_S, !out_valid_q, "emit over pending result")
  `RRIE_ASSERT_IMP(a_keep_range, tbl_we && cmd_i.op == OP_KEEP, w_q < rcnt_q, "keep write outside old table")

endmodule

/* hw/rtl/rect_region_include_exclude.sv */
// Include compares each stored entry with each scratch piece and clips or splits one of them,
// erases the piece (later pieces shift down) or drops the entry; exclude cuts each entry that
// overlaps the request into side pieces. Pieces are then appended; list emits stored entries.
// Throughput: one request at a time; the next is taken once its last result is registered.
// Reset (async, active low) empties the region and clears the overflow flag.
// Depends on rrie_pkg, rrie_ctrl and rrie_datapath.
module rect_region_include_exclude (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // left, top, right, bottom
  input  logic [1:0]  s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // out_left, out_top, out_right, out_bottom,
                                        // entry_count, overflow, pad
  output logic        m_axis_tuser_o,   // has_entry
  output logic        m_axis_tlast_o    // last
);
  import rrie_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  box_t              in_box, out_box;
  logic              out_ovf;
  logic [ECNT_W-1:0] out_cnt;

  assign in_box.l = s_axis_tdata_i[11:0];
  assign in_box.t = s_axis_tdata_i[23:12];
  assign in_box.r = s_axis_tdata_i[35:24];
  assign in_box.b = s_axis_tdata_i[47:36];

  rrie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  rrie_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_box_i    (in_box),
    .out_box_o   (out_box),
    .out_has_o   (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o),
    .out_ovf_o   (out_ovf),
    .out_cnt_o   (out_cnt),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {1'b0, out_ovf, out_cnt, out_box.b, out_box.r, out_box.t, out_box.l};

endmodule
